@@ rtl/line_clip_project_top_assert.svh @@
// Assertion macros for the line clip and projection block.
// Used by line_clip_project_top; needs clk_i and rst_ni in the including scope.
`ifndef LINE_CLIP_PROJECT_TOP_ASSERT_SVH
`define LINE_CLIP_PROJECT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LCP_ASSERT(lbl, prop, msg)
`define LCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/lcp_pkg.sv @@
// Shared types, constants and helper functions of the line clip block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lcp_pkg;

  // Coordinate width of every computed point.
  localparam int unsigned CW   = 32;
  // Plane distances: coordinate minus a nonnegative plane value of up to 32 bits.
  localparam int unsigned DW   = CW + 2;
  // Operand width of the multiply-divide unit.
  localparam int unsigned OPW  = CW + 4;
  // Magnitude width, product width, quotient width and sum width.
  localparam int unsigned MW   = OPW;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned QW   = 2 * CW;
  localparam int unsigned SW   = QW + 2;
  localparam int unsigned RW   = 31;
  localparam int unsigned PIXW = 16;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  dist_t;
  typedef logic signed [OPW-1:0] op_t;

  typedef enum logic [2:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_XGAIN  = 3'd2,
    REG_YGAIN  = 3'd3,
    REG_CENTRE = 3'd4,
    REG_VPMIN  = 3'd5,
    REG_VPMAX  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_PASS   = 2'd0,
    CLS_REJECT = 2'd1,
    CLS_CLIP_A = 2'd2,
    CLS_CLIP_B = 2'd3
  } cls_e;

  typedef struct packed {
    logic [RW-1:0] near_plane;
    logic [RW-1:0] far_plane;
    logic [RW-1:0] x_gain;
    logic [RW-1:0] y_gain;
    logic [31:0]   screen_centre;
    logic [31:0]   viewport_min;
    logic [31:0]   viewport_max;
  } cfg_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    dist_t  near_da;
    dist_t  near_db;
    cls_e   near_cls;
  } item_t;

  typedef struct packed {
    logic   visible;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } result_t;

  typedef struct packed {
    logic start;
    op_t  a;
    op_t  b;
    op_t  c;
  } md_req_t;

  typedef struct packed {
    logic                 idle;
    logic                 done;
    logic signed [QW-1:0] q;
  } md_rsp_t;

  // Decides what one plane does with a segment from the two end distances.
  function automatic cls_e classify(dist_t da, dist_t db);
    cls_e c;
    if (da > 0 && db > 0) begin
      c = CLS_PASS;
    end else if (da < 0 && db < 0) begin
      c = CLS_REJECT;
    end else if (da < 0) begin
      c = CLS_CLIP_A;
    end else if (db < 0) begin
      c = CLS_CLIP_B;
    end else begin
      c = CLS_PASS;
    end
    return c;
  endfunction

  function automatic coord_t sat_coord(logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    coord_t r;
    hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > hi) begin
      r = hi[CW-1:0];
    end else if (v < lo) begin
      r = lo[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Integer pixel to Q16.16.
  function automatic dist_t pix(logic [PIXW-1:0] p);
    return $signed({{(DW-2*PIXW){1'b0}}, p, {PIXW{1'b0}}});
  endfunction

endpackage

@@ rtl/line_clip_project_top.sv @@
// Top level of the line clip and projection block: configuration registers,
// input stage, segment queue, clipping sequencer and multiply-divide unit.
// Depends on lcp_pkg, lcp_front, lcp_fifo, lcp_muldiv, lcp_back.
`timescale 1ns / 1ps
`include "line_clip_project_top_assert.svh"
// Usage:
// Segments enter on the push/full channel: a transaction takes place at a
// rising edge with push high and full low, carrying both view-space endpoints.
// Results leave on the empty/pop channel: while empty is low the oldest result
// (visible flag and two screen points) is on the result ports, and it is
// taken at an edge with pop high. A rejected segment shows zero coordinates.
// A segment rejected at the near plane passes the input register, the queue
// and the sequencer before it is offered on the result ports. Every crossing
// point and every projected coordinate runs through one shared multiply-divide
// unit; a segment uses up to eighteen of its results. That unit sets the
// throughput. The input stage and a two-entry queue keep accepting segments
// while the sequencer works, and the result register lets the sequencer finish
// one more segment while the receiver stalls; after that full rises.
// Reset empties all queues and restores the register defaults. The user must
// see that registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
module line_clip_project_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           push,
  output logic           full,
  input  lcp_pkg::coord_t a_x_i,
  input  lcp_pkg::coord_t a_y_i,
  input  lcp_pkg::coord_t a_z_i,
  input  lcp_pkg::coord_t b_x_i,
  input  lcp_pkg::coord_t b_y_i,
  input  lcp_pkg::coord_t b_z_i,
  output logic           empty,
  input  logic           pop,
  output logic           visible_o,
  output lcp_pkg::coord_t start_x_o,
  output lcp_pkg::coord_t start_y_o,
  output lcp_pkg::coord_t end_x_o,
  output lcp_pkg::coord_t end_y_o
);
  import lcp_pkg::*;

  cfg_t    cfg_q;
  logic    front_ready;
  logic    front_valid;
  item_t   front_item;
  logic    fifo_ready;
  logic    item_valid;
  item_t   item;
  logic    item_pop;
  md_req_t md_req;
  md_rsp_t md_rsp;
  logic    res_valid;
  result_t res;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_plane    <= 31'd327680;
      cfg_q.far_plane     <= 31'd983040;
      cfg_q.x_gain        <= 31'd65536;
      cfg_q.y_gain        <= 31'd65536;
      cfg_q.screen_centre <= '0;
      cfg_q.viewport_min  <= '0;
      cfg_q.viewport_max  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_NEAR:   cfg_q.near_plane    <= cfg_wdata_i[RW-1:0];
        REG_FAR:    cfg_q.far_plane     <= cfg_wdata_i[RW-1:0];
        REG_XGAIN:  cfg_q.x_gain        <= cfg_wdata_i[RW-1:0];
        REG_YGAIN:  cfg_q.y_gain        <= cfg_wdata_i[RW-1:0];
        REG_CENTRE: cfg_q.screen_centre <= cfg_wdata_i;
        REG_VPMIN:  cfg_q.viewport_min  <= cfg_wdata_i;
        REG_VPMAX:  cfg_q.viewport_max  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  lcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_z_i       (a_z_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_z_i       (b_z_i),
    .ready_o     (front_ready),
    .out_valid_o (front_valid),
    .out_item_o  (front_item),
    .out_ready_i (fifo_ready)
  );

  assign full = !front_ready;

  lcp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_item_i  (front_item),
    .wr_ready_o (fifo_ready),
    .rd_valid_o (item_valid),
    .rd_item_o  (item),
    .rd_pop_i   (item_pop)
  );

  lcp_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  lcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .md_req_o     (md_req),
    .md_rsp_i     (md_rsp),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty     = !res_valid;
  assign visible_o = res.visible;
  assign start_x_o = res.start_x;
  assign start_y_o = res.start_y;
  assign end_x_o   = res.end_x;
  assign end_y_o   = res.end_y;

  // A rejected segment must come out with all coordinates cleared.
  `LCP_ASSERT(a_reject_zero, !empty && !visible_o |-> (start_x_o == '0) && (start_y_o == '0) && (end_x_o == '0) && (end_y_o == '0), "rejected segment carries coordinates")
  // The sequencer only starts the divider when it is free.
  `LCP_ASSERT(a_md_start_idle, md_req.start |-> md_rsp.idle, "divider started while busy")
  // A divider result only follows a cycle of work.
  `LCP_ASSERT(a_md_done_busy, md_rsp.done |-> !$past(md_rsp.idle), "divider done without work")
  // No result is offered while reset is held.
  `LCP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result offered during reset")

endmodule

@@ rtl/lcp_front.sv @@
// Input stage: registers one segment and classifies it against the near plane.
// Depends on lcp_pkg.
`timescale 1ns / 1ps
module lcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcp_pkg::cfg_t  cfg_i,
  input  logic           push_i,
  input  lcp_pkg::coord_t a_x_i,
  input  lcp_pkg::coord_t a_y_i,
  input  lcp_pkg::coord_t a_z_i,
  input  lcp_pkg::coord_t b_x_i,
  input  lcp_pkg::coord_t b_y_i,
  input  lcp_pkg::coord_t b_z_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output lcp_pkg::item_t out_item_o,
  input  logic           out_ready_i
);
  import lcp_pkg::*;

  logic  valid_q;
  item_t item_q;
  dist_t nz;
  dist_t da;
  dist_t db;

  assign nz = $signed(DW'(cfg_i.near_plane));
  assign da = DW'(a_z_i) - nz;
  assign db = DW'(b_z_i) - nz;

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      item_q.ax       <= a_x_i;
      item_q.ay       <= a_y_i;
      item_q.az       <= a_z_i;
      item_q.bx       <= b_x_i;
      item_q.by       <= b_y_i;
      item_q.bz       <= b_z_i;
      item_q.near_da  <= da;
      item_q.near_db  <= db;
      item_q.near_cls <= classify(da, db);
    end
  end

endmodule

@@ rtl/lcp_fifo.sv @@
// Short queue of classified segments between the input stage and the clipper.
// Depends on lcp_pkg.
`timescale 1ns / 1ps
module lcp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  lcp_pkg::item_t wr_item_i,
  output logic           wr_ready_o,
  output logic           rd_valid_o,
  output lcp_pkg::item_t rd_item_o,
  input  logic           rd_pop_i
);
  import lcp_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q;
  logic [FIFO_AW-1:0] rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready_o = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rd_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_rd) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= wr_item_i;
    end
  end

endmodule

@@ rtl/lcp_muldiv.sv @@
// Iterative signed a*b/c unit: shift-add multiply, then restoring division.
// Quotient truncates toward zero; a zero divisor gives zero. Depends on lcp_pkg.
`timescale 1ns / 1ps
module lcp_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcp_pkg::md_req_t req_i,
  output lcp_pkg::md_rsp_t rsp_o
);
  import lcp_pkg::*;

  localparam int unsigned CNTW = $clog2(PW);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_DONE = 4'b1000
  } md_st_e;

  md_st_e           st_q, st_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [MW-1:0]    ma_q;
  logic [MW-1:0]    mb_q;
  logic [MW-1:0]    mc_q;
  logic [PW-1:0]    acc_q;
  logic [MW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic             neg_q;
  logic             zero_q;
  logic [MW:0]      rem_sh;
  logic [MW:0]      rem_sub;
  logic             rem_ge;

  function automatic logic [MW-1:0] mag(op_t v);
    return v[OPW-1] ? MW'(-v) : MW'(v);
  endfunction

  assign rem_sh  = {rem_q, acc_q[PW-1]};
  assign rem_ge  = rem_sh >= {1'b0, mc_q};
  assign rem_sub = rem_sh - {1'b0, mc_q};

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      MD_IDLE: begin
        if (req_i.start) begin
          st_d  = MD_MUL;
          cnt_d = '0;
        end
      end
      MD_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(MW - 1)) begin
          st_d  = MD_DIV;
          cnt_d = '0;
        end
      end
      MD_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(PW - 1)) begin
          st_d = MD_DONE;
        end
      end
      MD_DONE: st_d = MD_IDLE;
      default: st_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= MD_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == MD_IDLE && req_i.start) begin
      ma_q   <= mag(req_i.a);
      mb_q   <= mag(req_i.b);
      mc_q   <= mag(req_i.c);
      acc_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= req_i.a[OPW-1] ^ req_i.b[OPW-1] ^ req_i.c[OPW-1];
      zero_q <= req_i.c == '0;
    end else if (st_q == MD_MUL) begin
      acc_q <= {acc_q[PW-2:0], 1'b0} + (mb_q[MW-1] ? PW'(ma_q) : '0);
      mb_q  <= {mb_q[MW-2:0], 1'b0};
    end else if (st_q == MD_DIV) begin
      acc_q <= {acc_q[PW-2:0], 1'b0};
      rem_q <= rem_ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
      quo_q <= {quo_q[QW-2:0], rem_ge};
    end
  end

  assign rsp_o.idle = st_q == MD_IDLE;
  assign rsp_o.done = st_q == MD_DONE;
  assign rsp_o.q    = zero_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

endmodule

@@ rtl/lcp_back.sv @@
// Clipping sequencer: near and far planes, depth check, projection and viewport edges,
// with crossing points from the shared multiply-divide unit. Depends on lcp_pkg.
`timescale 1ns / 1ps
module lcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcp_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  lcp_pkg::item_t    item_i,
  output logic              item_pop_o,
  output lcp_pkg::md_req_t  md_req_o,
  input  lcp_pkg::md_rsp_t  md_rsp_i,
  output logic              res_valid_o,
  output lcp_pkg::result_t  res_o,
  input  logic              res_pop_i
);
  import lcp_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_CLASS  = 6'b000010,
    B_ZCHK   = 6'b000100,
    B_MDGO   = 6'b001000,
    B_MDWAIT = 6'b010000,
    B_DONE   = 6'b100000
  } back_st_e;

  typedef enum logic [2:0] {
    PL_NEAR  = 3'd0,
    PL_FAR   = 3'd1,
    PL_TOP   = 3'd2,
    PL_BOT   = 3'd3,
    PL_RIGHT = 3'd4,
    PL_LEFT  = 3'd5
  } plane_e;

  back_st_e st_q, st_d;
  plane_e   pl_q;
  logic     proj_q;
  logic [1:0] k_q;
  logic     side_a_q;
  logic     ok_q;
  logic     res_valid_q;
  cls_e     ncls_q;
  dist_t    da_q, db_q;
  coord_t   ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  coord_t   sax_q, say_q, sbx_q, sby_q;
  coord_t   tmp_x_q, tmp_y_q;
  result_t  res_q;

  dist_t    cur_da, cur_db;
  dist_t    nz_unused_far;
  dist_t    top_e, bot_e, right_e, left_e, cx, cy;
  cls_e     cls;
  back_st_e adv_st;
  plane_e   adv_pl;
  logic     is3d;
  logic     last_k;
  logic     res_free;
  coord_t   pa_k, pb_k;
  coord_t   pt;
  coord_t   proj_x, proj_y;
  op_t      pj_a, pj_b, pj_c;
  logic signed [QW-1:0] md_q;

  assign md_q          = md_rsp_i.q;
  assign nz_unused_far = $signed(DW'(cfg_i.far_plane));
  assign top_e   = pix(cfg_i.viewport_min[31:16]);
  assign left_e  = pix(cfg_i.viewport_min[15:0]);
  assign bot_e   = pix(cfg_i.viewport_max[31:16]);
  assign right_e = pix(cfg_i.viewport_max[15:0]);
  assign cx      = pix(cfg_i.screen_centre[15:0]);
  assign cy      = pix(cfg_i.screen_centre[31:16]);

  always_comb begin
    unique case (pl_q)
      PL_NEAR: begin
        cur_da = da_q;
        cur_db = db_q;
      end
      PL_FAR: begin
        cur_da = nz_unused_far - DW'(az_q);
        cur_db = nz_unused_far - DW'(bz_q);
      end
      PL_TOP: begin
        cur_da = DW'(say_q) - top_e;
        cur_db = DW'(sby_q) - top_e;
      end
      PL_BOT: begin
        cur_da = bot_e - DW'(say_q);
        cur_db = bot_e - DW'(sby_q);
      end
      PL_RIGHT: begin
        cur_da = right_e - DW'(sax_q);
        cur_db = right_e - DW'(sbx_q);
      end
      default: begin
        cur_da = DW'(sax_q) - left_e;
        cur_db = DW'(sbx_q) - left_e;
      end
    endcase
  end

  assign cls = (pl_q == PL_NEAR) ? ncls_q : classify(cur_da, cur_db);

  // Where a segment goes once the current plane is behind it.
  always_comb begin
    adv_st = B_CLASS;
    adv_pl = pl_q;
    unique case (pl_q)
      PL_NEAR:  adv_pl = PL_FAR;
      PL_FAR: begin
        adv_st = B_ZCHK;
        adv_pl = PL_TOP;
      end
      PL_TOP:   adv_pl = PL_BOT;
      PL_BOT:   adv_pl = PL_RIGHT;
      PL_RIGHT: adv_pl = PL_LEFT;
      default:  adv_st = B_DONE;
    endcase
  end

  assign is3d   = (pl_q == PL_NEAR) || (pl_q == PL_FAR);
  assign last_k = is3d ? (k_q == 2'd2) : (k_q == 2'd1);

  always_comb begin
    if (is3d) begin
      case (k_q)
        2'd0: begin
          pa_k = ax_q;
          pb_k = bx_q;
        end
        2'd1: begin
          pa_k = ay_q;
          pb_k = by_q;
        end
        default: begin
          pa_k = az_q;
          pb_k = bz_q;
        end
      endcase
    end else begin
      case (k_q)
        2'd0: begin
          pa_k = sax_q;
          pb_k = sbx_q;
        end
        default: begin
          pa_k = say_q;
          pb_k = sby_q;
        end
      endcase
    end
  end

  always_comb begin
    case (k_q)
      2'd0: begin
        pj_a = OPW'(ax_q);
        pj_b = $signed(OPW'(cfg_i.x_gain));
        pj_c = OPW'(az_q);
      end
      2'd1: begin
        pj_a = OPW'(ay_q);
        pj_b = $signed(OPW'(cfg_i.y_gain));
        pj_c = OPW'(az_q);
      end
      2'd2: begin
        pj_a = OPW'(bx_q);
        pj_b = $signed(OPW'(cfg_i.x_gain));
        pj_c = OPW'(bz_q);
      end
      default: begin
        pj_a = OPW'(by_q);
        pj_b = $signed(OPW'(cfg_i.y_gain));
        pj_c = OPW'(bz_q);
      end
    endcase
  end

  assign md_req_o.start = st_q == B_MDGO;
  assign md_req_o.a     = proj_q ? pj_a : OPW'(pb_k) - OPW'(pa_k);
  assign md_req_o.b     = proj_q ? pj_b : OPW'(da_q);
  assign md_req_o.c     = proj_q ? pj_c : OPW'(da_q) - OPW'(db_q);

  assign pt     = sat_coord(SW'(pa_k) + SW'(md_q));
  assign proj_x = sat_coord(SW'(cx) + SW'(md_q));
  assign proj_y = sat_coord(SW'(cy) - SW'(md_q));

  assign item_pop_o  = (st_q == B_IDLE) && item_valid_i;
  assign res_free    = !res_valid_q || res_pop_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (item_valid_i) begin
          st_d = B_CLASS;
        end
      end
      B_CLASS: begin
        unique case (cls) inside
          CLS_PASS:               st_d = adv_st;
          CLS_REJECT:             st_d = B_DONE;
          CLS_CLIP_A, CLS_CLIP_B: st_d = B_MDGO;
          default:                st_d = B_DONE;
        endcase
      end
      B_ZCHK: begin
        st_d = (az_q <= 0 || bz_q <= 0) ? B_DONE : B_MDGO;
      end
      B_MDGO: st_d = B_MDWAIT;
      B_MDWAIT: begin
        if (md_rsp_i.done) begin
          if (proj_q) begin
            st_d = (k_q == 2'd3) ? B_CLASS : B_MDGO;
          end else begin
            st_d = last_k ? adv_st : B_MDGO;
          end
        end
      end
      B_DONE: begin
        if (res_free) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      pl_q        <= PL_NEAR;
      proj_q      <= 1'b0;
      k_q         <= '0;
      side_a_q    <= 1'b0;
      ok_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_DONE && res_free) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (st_q)
        B_IDLE: begin
          pl_q   <= PL_NEAR;
          proj_q <= 1'b0;
        end
        B_CLASS: begin
          if (cls == CLS_PASS) begin
            pl_q <= adv_pl;
            ok_q <= 1'b1;
          end else if (cls == CLS_REJECT) begin
            ok_q <= 1'b0;
          end else begin
            side_a_q <= cls == CLS_CLIP_A;
            k_q      <= '0;
          end
        end
        B_ZCHK: begin
          ok_q   <= !(az_q <= 0 || bz_q <= 0);
          proj_q <= 1'b1;
          k_q    <= '0;
        end
        B_MDWAIT: begin
          if (md_rsp_i.done) begin
            if (proj_q) begin
              if (k_q == 2'd3) begin
                proj_q <= 1'b0;
                pl_q   <= PL_TOP;
              end else begin
                k_q <= k_q + 2'd1;
              end
            end else if (last_k) begin
              pl_q <= adv_pl;
              ok_q <= 1'b1;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE && item_valid_i) begin
      ax_q   <= item_i.ax;
      ay_q   <= item_i.ay;
      az_q   <= item_i.az;
      bx_q   <= item_i.bx;
      by_q   <= item_i.by;
      bz_q   <= item_i.bz;
      da_q   <= item_i.near_da;
      db_q   <= item_i.near_db;
      ncls_q <= item_i.near_cls;
    end
    if (st_q == B_CLASS) begin
      da_q <= cur_da;
      db_q <= cur_db;
    end
    if (st_q == B_MDWAIT && md_rsp_i.done) begin
      if (proj_q) begin
        case (k_q)
          2'd0:    sax_q <= proj_x;
          2'd1:    say_q <= proj_y;
          2'd2:    sbx_q <= proj_x;
          default: sby_q <= proj_y;
        endcase
      end else if (!last_k) begin
        if (k_q == 2'd0) begin
          tmp_x_q <= pt;
        end else begin
          tmp_y_q <= pt;
        end
      end else if (is3d) begin
        if (side_a_q) begin
          ax_q <= tmp_x_q;
          ay_q <= tmp_y_q;
          az_q <= pt;
        end else begin
          bx_q <= tmp_x_q;
          by_q <= tmp_y_q;
          bz_q <= pt;
        end
      end else begin
        if (side_a_q) begin
          sax_q <= tmp_x_q;
          say_q <= pt;
        end else begin
          sbx_q <= tmp_x_q;
          sby_q <= pt;
        end
      end
    end
    if (st_q == B_DONE && res_free) begin
      res_q.visible <= ok_q;
      res_q.start_x <= ok_q ? sax_q : '0;
      res_q.start_y <= ok_q ? say_q : '0;
      res_q.end_x   <= ok_q ? sbx_q : '0;
      res_q.end_y   <= ok_q ? sby_q : '0;
    end
  end

endmodule
